### sv/rrss_pkg.sv
// Shared types and constants for the round-robin slice scheduler.
package rrss_pkg;

    // Command codes carried by the command field.
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_SLICE = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LD_SCAN,
        ST_LD_SHIFT,
        ST_LD_WRITE,
        ST_SL_ADMIT0,
        ST_SL_JUMP,
        ST_SL_ADMIT1,
        ST_SL_POP,
        ST_SL_RUN,
        ST_SL_ADMIT2,
        ST_SL_FINISH,
        ST_DONE
    } rrss_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic clear;       // reset scheduling state
        logic scan_init;   // start insertion search
        logic scan_step;   // compare one table entry
        logic shift_step;  // move one entry up
        logic write_new;   // store the loaded task
        logic admit_step;  // test/push one arrival
        logic admit_sel;   // 0: limit is time, 1: limit is time + run
        logic jump;        // time jumps to next arrival
        logic pop;         // pop front of ready queue, read task
        logic run;         // compute run length
        logic finish;      // update time and requeue
        logic out_slice;   // emit slice result
        logic out_done;    // emit all_done result
        logic out_full;    // emit table_full result
        logic out_zero;    // emit zero result
    } rrss_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic sched_begun;  // next_arrival_index nonzero
        logic table_full;
        logic scan_done;    // insertion point found
        logic shift_done;
        logic admit_more;   // next arrival is within limit
        logic pending;      // unseen tasks remain
        logic queue_empty;
    } rrss_stat_t;

endpackage

### sv/rrss_ctrl.sv
// Controller state machine of the round-robin slice scheduler.
module rrss_ctrl
    import rrss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    input  rrss_stat_t stat,
    output rrss_cmd_t  cmd,
    output logic       busy
);

    rrss_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (command)
                        CMD_CLEAR: state_next = ST_CLEAR;
                        CMD_LOAD:
                        begin
                            if (stat.sched_begun)
                            begin
                                cmd.out_zero = 1'b1;
                            end
                            else if (stat.table_full)
                            begin
                                cmd.out_full = 1'b1;
                            end
                            else
                            begin
                                cmd.scan_init = 1'b1;
                                state_next = ST_LD_SCAN;
                            end
                        end
                        CMD_SLICE: state_next = ST_SL_ADMIT0;
                        default: cmd.out_zero = 1'b1;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                cmd.out_zero = 1'b1;
                state_next = ST_IDLE;
            end
            ST_LD_SCAN:
            begin
                if (stat.scan_done)
                    state_next = ST_LD_SHIFT;
                else
                    cmd.scan_step = 1'b1;
            end
            ST_LD_SHIFT:
            begin
                if (stat.shift_done)
                    state_next = ST_LD_WRITE;
                else
                    cmd.shift_step = 1'b1;
            end
            ST_LD_WRITE:
            begin
                cmd.write_new = 1'b1;
                cmd.out_zero = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SL_ADMIT0:
            begin
                if (stat.admit_more)
                    cmd.admit_step = 1'b1;
                else if (!stat.queue_empty)
                    state_next = ST_SL_POP;
                else if (stat.pending)
                    state_next = ST_SL_JUMP;
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.out_done = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SL_JUMP:
            begin
                cmd.jump = 1'b1;
                state_next = ST_SL_ADMIT1;
            end
            ST_SL_ADMIT1:
            begin
                if (stat.admit_more)
                    cmd.admit_step = 1'b1;
                else
                    state_next = ST_SL_POP;
            end
            ST_SL_POP:
            begin
                cmd.pop = 1'b1;
                state_next = ST_SL_RUN;
            end
            ST_SL_RUN:
            begin
                cmd.run = 1'b1;
                state_next = ST_SL_ADMIT2;
            end
            ST_SL_ADMIT2:
            begin
                cmd.admit_sel = 1'b1;
                if (stat.admit_more)
                    cmd.admit_step = 1'b1;
                else
                    state_next = ST_SL_FINISH;
            end
            ST_SL_FINISH:
            begin
                cmd.finish = 1'b1;
                cmd.out_slice = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### sv/rrss_dp.sv
// Datapath of the round-robin slice scheduler: task table, ready queue, time.
module rrss_dp
    import rrss_pkg::*;
#(
    parameter int MAX_TASKS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  rrss_cmd_t   cmd,
    output rrss_stat_t  stat,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic [15:0] task_id,
    input  logic [15:0] arrival_time,
    input  logic [15:0] burst_length,
    output logic [15:0] slice_task_id,
    output logic [31:0] slice_start,
    output logic [15:0] slice_length,
    output logic        task_finished,
    output logic        all_done,
    output logic        table_full,
    output logic        done
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int TW = CW + 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_TASKS);
    localparam logic [TW-1:0] MAXW = TW'(MAX_TASKS);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

    // Task table and ready queue.
    logic [15:0] ids_mem [MAX_TASKS];
    logic [15:0] arr_mem [MAX_TASKS];
    logic [15:0] rem_mem [MAX_TASKS];
    logic [IW-1:0] rq_mem [MAX_TASKS];

    logic [15:0] quantum_reg;
    logic [IW-1:0] head_reg;
    logic [CW-1:0] count_reg, loaded_reg, nai_reg, pos_reg;
    logic [CW-1:0] total_reg;
    logic [31:0] time_reg;
    logic [15:0] id_lat_reg, arr_lat_reg, burst_lat_reg;
    logic [IW-1:0] cur_reg;
    logic [15:0] cur_id_reg, cur_rem_reg, run_reg;
    logic [31:0] end_reg;

    logic [IW-1:0] pos_i, nai_i, tail_i, last_sh;
    logic [TW-1:0] tail_sum;
    logic [15:0] qeff, scan_arr, scan_id, nai_arr;
    logic        lim_ok;

    assign pos_i  = pos_reg[IW-1:0];
    assign nai_i  = nai_reg[IW-1:0];
    assign last_sh = IW'(loaded_reg - CW'(1));
    // The queue tail wraps at the table depth.
    assign tail_sum = {1'b0, CW'(head_reg)} + {1'b0, count_reg};
    assign tail_i = (tail_sum >= MAXW) ? IW'(tail_sum - MAXW) : IW'(tail_sum);
    assign scan_arr = arr_mem[pos_i];
    assign scan_id  = ids_mem[pos_i];
    assign nai_arr  = arr_mem[nai_i];
    assign qeff = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;

    // The admit limit is time, or time plus run without wrap.
    always_comb
    begin
        if (cmd.admit_sel)
            lim_ok = ({17'd0, nai_arr} <= ({1'b0, time_reg} + {17'd0, run_reg}));
        else
            lim_ok = ({16'd0, nai_arr} <= time_reg);
    end

    assign stat.sched_begun = (nai_reg != '0);
    assign stat.table_full  = (loaded_reg >= MAXC);
    assign stat.scan_done   = (pos_reg == loaded_reg) ||
                              (arr_lat_reg < scan_arr) ||
                              (arr_lat_reg == scan_arr && id_lat_reg < scan_id);
    assign stat.shift_done  = (loaded_reg == pos_reg);
    assign stat.pending     = (nai_reg < loaded_reg);
    assign stat.admit_more  = stat.pending && lim_ok;
    assign stat.queue_empty = (count_reg == '0);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quantum_reg <= 16'd4;
        else if (cfg_we)
            quantum_reg <= cfg_data;
    end

    // Control counters and time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            count_reg <= '0;
            loaded_reg <= '0;
            nai_reg <= '0;
            pos_reg <= '0;
            time_reg <= '0;
        end
        else if (cmd.clear)
        begin
            head_reg <= '0;
            count_reg <= '0;
            loaded_reg <= '0;
            nai_reg <= '0;
            time_reg <= '0;
        end
        else
        begin
            if (cmd.scan_init)
                pos_reg <= '0;
            if (cmd.scan_step)
                pos_reg <= pos_reg + CW'(1);
            if (cmd.shift_step)
                loaded_reg <= loaded_reg - CW'(1);
            if (cmd.write_new)
                loaded_reg <= total_reg + CW'(1);
            if (cmd.admit_step)
            begin
                nai_reg <= nai_reg + CW'(1);
                if (count_reg < MAXC)
                    count_reg <= count_reg + CW'(1);
            end
            if (cmd.jump)
                time_reg <= {16'd0, nai_arr};
            if (cmd.pop)
            begin
                head_reg <= (head_reg == LAST_IDX) ? '0 : head_reg + IW'(1);
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.finish)
            begin
                time_reg <= end_reg;
                if (cur_rem_reg != run_reg && count_reg < MAXC)
                    count_reg <= count_reg + CW'(1);
            end
        end
    end

    // Shifting walks loaded_reg down to the insertion point as a counter.
    // The table size before the load is kept here; on write the size becomes it plus one.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
            total_reg <= loaded_reg;
    end

    // Table, queue and slice registers.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            id_lat_reg <= task_id;
            arr_lat_reg <= arrival_time;
            burst_lat_reg <= burst_length;
        end
        if (cmd.shift_step)
        begin
            ids_mem[IW'(loaded_reg)] <= ids_mem[last_sh];
            arr_mem[IW'(loaded_reg)] <= arr_mem[last_sh];
            rem_mem[IW'(loaded_reg)] <= rem_mem[last_sh];
        end
        if (cmd.write_new)
        begin
            ids_mem[pos_i] <= id_lat_reg;
            arr_mem[pos_i] <= arr_lat_reg;
            rem_mem[pos_i] <= burst_lat_reg;
        end
        if (cmd.admit_step && count_reg < MAXC)
            rq_mem[tail_i] <= nai_i;
        if (cmd.pop)
        begin
            cur_reg <= rq_mem[head_reg];
            cur_id_reg <= ids_mem[rq_mem[head_reg]];
            cur_rem_reg <= rem_mem[rq_mem[head_reg]];
        end
        if (cmd.run)
        begin
            run_reg <= (cur_rem_reg < qeff) ? cur_rem_reg : qeff;
        end
        if (cmd.admit_sel && !cmd.admit_step)
            end_reg <= time_reg + {16'd0, run_reg};
        if (cmd.finish)
        begin
            rem_mem[cur_reg] <= cur_rem_reg - run_reg;
            if (cur_rem_reg != run_reg && count_reg < MAXC)
                rq_mem[tail_i] <= cur_reg;
        end
    end

    // Result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
            slice_task_id <= '0;
            slice_start <= '0;
            slice_length <= '0;
            task_finished <= 1'b0;
            all_done <= 1'b0;
            table_full <= 1'b0;
        end
        else
        begin
            done <= cmd.out_slice | cmd.out_done | cmd.out_full | cmd.out_zero;
            slice_task_id <= cmd.out_slice ? cur_id_reg : 16'd0;
            slice_start <= cmd.out_slice ? time_reg : 32'd0;
            slice_length <= cmd.out_slice ? run_reg : 16'd0;
            task_finished <= cmd.out_slice && (cur_rem_reg == run_reg);
            all_done <= cmd.out_done;
            table_full <= cmd.out_full;
        end
    end

endmodule

### sv/round_robin_slice_scheduler.sv
// Top level of the round-robin slice scheduler.
// Raise start with a command while busy is low; exactly one result follows, shown for
// one cycle with done high, and it must be captured then since it cannot be held.
// A no-operation command or a refused load gives its result in the next cycle
// without raising busy. A clear holds busy in its clear state; its result shows in
// the cycle after. A load holds busy while it searches the task table and shifts
// later entries up, one entry per cycle, then writes the new task. A slice holds
// busy while it admits arrivals to the ready queue, jumps time to the next arrival
// if the queue is empty, pops and runs a task, admits arrivals up to its end and
// requeues it if unfinished; with no task left it gives the all-done result. A result
// of a command that raised busy shows in the first cycle with busy low. quantum_length
// must be written through cfg_we/cfg_data only while busy is low; the block does not enforce this.
module round_robin_slice_scheduler
    import rrss_pkg::*;
#(
    parameter int MAX_TASKS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic [1:0]  command,
    input  logic [15:0] task_id,
    input  logic [15:0] arrival_time,
    input  logic [15:0] burst_length,
    output logic        done,
    output logic [15:0] slice_task_id,
    output logic [31:0] slice_start,
    output logic [15:0] slice_length,
    output logic        task_finished,
    output logic        all_done,
    output logic        table_full
);

    rrss_cmd_t  cmd;
    rrss_stat_t stat;
    logic       ctrl_busy;

    rrss_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .command(command),
        .stat(stat), .cmd(cmd), .busy(ctrl_busy)
    );

    rrss_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .task_id(task_id), .arrival_time(arrival_time), .burst_length(burst_length),
        .slice_task_id(slice_task_id), .slice_start(slice_start),
        .slice_length(slice_length), .task_finished(task_finished),
        .all_done(all_done), .table_full(table_full), .done(done)
    );

    // The controller is busy in every state but idle.
    assign busy = ctrl_busy;

endmodule

### sv/rrss_checker.sv
// Port checker for the round-robin slice scheduler, bound to the top level.
module rrss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [15:0] slice_length,
    input logic        task_finished,
    input logic        all_done,
    input logic        table_full
);

    // The all-done flag never appears with table_full or task_finished.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(all_done && table_full) && !(all_done && task_finished))
        else $error("conflicting result flags");

    // Flags only appear with done.
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> !all_done && !table_full && !task_finished)
        else $error("flag without done");

    // Empty slice reports nothing.
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (all_done || table_full)) |-> slice_length == 16'd0)
        else $error("length on non-slice result");

    // A result is only shown while the block is idle.
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    // An accepted item gives its result at once or keeps the block busy.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted item dropped");

endmodule

bind round_robin_slice_scheduler rrss_checker u_rrss_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .slice_length(slice_length), .task_finished(task_finished),
    .all_done(all_done), .table_full(table_full)
);

### verif/tb_top.sv
// Self-checking testbench for the round-robin slice scheduler.
`timescale 1ns / 100ps

module tb_top
    import rrss_pkg::*;
;

    localparam int TABLE_DEPTH = 16;
    localparam int STALL_LIMIT = 5000;

    // One command item as driven on the input ports.
    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] id;
        logic [15:0] arr;
        logic [15:0] burst;
        bit          is_cfg;
        logic [15:0] cfg_value;
        bit          drain;
    } sched_item_t;

    // One slice result as seen on the output ports.
    typedef struct {
        logic [15:0] task_id;
        logic [31:0] start_time;
        logic [15:0] length;
        logic        finished;
        logic        all_done;
        logic        full;
    } slice_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cfg_we;
    logic [15:0] cfg_data;
    logic [1:0]  command;
    logic [15:0] task_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;
    logic        done;
    logic [15:0] slice_task_id;
    logic [31:0] slice_start;
    logic [15:0] slice_length;
    logic        task_finished;
    logic        all_done;
    logic        table_full;

    round_robin_slice_scheduler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .command      (command),
        .task_id      (task_id),
        .arrival_time (arrival_time),
        .burst_length (burst_length),
        .done         (done),
        .slice_task_id(slice_task_id),
        .slice_start  (slice_start),
        .slice_length (slice_length),
        .task_finished(task_finished),
        .all_done     (all_done),
        .table_full   (table_full)
    );

    // Predictor state.
    logic [15:0] tbl_id     [TABLE_DEPTH];
    logic [15:0] tbl_arr    [TABLE_DEPTH];
    logic [15:0] tbl_remain [TABLE_DEPTH];
    logic [3:0]  rq_slot    [TABLE_DEPTH];
    int unsigned rq_head, rq_count, n_loaded, n_admitted;
    logic [31:0] sched_time;
    logic [15:0] quantum;

    sched_item_t pending_items[$];
    slice_t      expected_slices[$];
    int          mismatches;
    int          send_idle_pct;
    int          stall_cycles;
    bit          stim_done;

    // Driver bookkeeping.
    logic        accepted;
    sched_item_t cur;
    bit          holding;
    int          drain_wait;
    int          cfg_writes;

    // Admit every unseen task arriving no later than limit; queue it if the ready queue has room.
    function automatic void admit_arrivals(input logic [32:0] limit);
        while (n_admitted < n_loaded && {17'd0, tbl_arr[n_admitted]} <= limit) begin
            if (rq_count < TABLE_DEPTH) begin
                rq_slot[(rq_head + rq_count) % TABLE_DEPTH] = n_admitted[3:0];
                rq_count++;
            end
            n_admitted++;
        end
    endfunction

    // Apply one command to the predictor and return the slice it produces.
    function automatic slice_t predict_slice(input sched_item_t it);
        slice_t      r;
        int unsigned pos, slot;
        logic [15:0] q, run;
        r = '{default: '0};
        case (it.cmd)
            CMD_CLEAR: begin
                rq_head = 0; rq_count = 0; n_loaded = 0; n_admitted = 0;
                sched_time = '0;
            end
            CMD_LOAD: begin
                if (n_admitted == 0) begin
                    if (n_loaded >= TABLE_DEPTH) begin
                        r.full = 1'b1;
                    end
                    else begin
                        pos = n_loaded;
                        for (int i = 0; i < n_loaded; i++) begin
                            if (it.arr < tbl_arr[i] ||
                                (it.arr == tbl_arr[i] && it.id < tbl_id[i])) begin
                                pos = i;
                                break;
                            end
                        end
                        for (int i = n_loaded; i > pos; i--) begin
                            tbl_id[i] = tbl_id[i-1];
                            tbl_arr[i] = tbl_arr[i-1];
                            tbl_remain[i] = tbl_remain[i-1];
                        end
                        tbl_id[pos] = it.id;
                        tbl_arr[pos] = it.arr;
                        tbl_remain[pos] = it.burst;
                        n_loaded++;
                    end
                end
            end
            CMD_SLICE: begin
                admit_arrivals({1'b0, sched_time});
                if (rq_count == 0) begin
                    if (n_admitted < n_loaded) begin
                        sched_time = {16'd0, tbl_arr[n_admitted]};
                        admit_arrivals({1'b0, sched_time});
                    end
                    else begin
                        r.all_done = 1'b1;
                        return r;
                    end
                end
                slot = rq_slot[rq_head];
                rq_head = (rq_head + 1) % TABLE_DEPTH;
                rq_count--;
                q = (quantum == 0) ? 16'd1 : quantum;
                run = (tbl_remain[slot] < q) ? tbl_remain[slot] : q;
                admit_arrivals({1'b0, sched_time} + {17'd0, run});
                r.task_id = tbl_id[slot];
                r.start_time = sched_time;
                r.length = run;
                sched_time = sched_time + {16'd0, run};
                tbl_remain[slot] = tbl_remain[slot] - run;
                if (tbl_remain[slot] != 0) begin
                    rq_slot[(rq_head + rq_count) % TABLE_DEPTH] = slot[3:0];
                    rq_count++;
                end
                else begin
                    r.finished = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic sched_item_t make_cmd(input logic [1:0] c, input logic [15:0] id,
                                             input logic [15:0] arr, input logic [15:0] b);
        sched_item_t it;
        it = '{cmd: c, id: id, arr: arr, burst: b, is_cfg: 1'b0, cfg_value: 16'd0,
               drain: 1'b0};
        return it;
    endfunction

    function automatic sched_item_t make_cfg(input logic [15:0] v);
        sched_item_t it;
        it = make_cmd(CMD_NOP, 16'd0, 16'd0, 16'd0);
        it.is_cfg = 1'b1;
        it.cfg_value = v;
        it.drain = 1'b1;
        return it;
    endfunction

    // Queue a job set: clear, loads, then random slices with occasional loads and no-ops.
    task automatic add_job_set(input int n_tasks, input int narrow);
        int slices;
        pending_items.push_back(make_cmd(CMD_CLEAR, 16'($urandom), 16'($urandom),
                                         16'($urandom)));
        for (int i = 0; i < n_tasks; i++) begin
            if (narrow != 0)
                pending_items.push_back(make_cmd(CMD_LOAD, 16'($urandom_range(0, 7)),
                    16'($urandom_range(0, 40)), 16'($urandom_range(0, 12))));
            else
                pending_items.push_back(make_cmd(CMD_LOAD, 16'($urandom), 16'($urandom),
                                                 16'($urandom)));
        end
        slices = $urandom_range(n_tasks, n_tasks * 4 + 4);
        for (int i = 0; i < slices; i++) begin
            if ($urandom_range(0, 19) == 0)
                pending_items.push_back(make_cmd(CMD_LOAD, 16'($urandom), 16'($urandom),
                                                 16'($urandom)));
            else if ($urandom_range(0, 29) == 0)
                pending_items.push_back(make_cmd(CMD_NOP, 16'($urandom), 16'($urandom),
                                                 16'($urandom)));
            else
                pending_items.push_back(make_cmd(CMD_SLICE, 16'($urandom), 16'($urandom),
                                                 16'($urandom)));
        end
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stimulus plan.
    initial
    begin
        int count;
        int sz;
        logic [15:0] quanta [6];
        quanta = '{16'd0, 16'd1, 16'd65535, 16'd4, 16'd3, 16'd7};
        rst_n = 1'b0;
        // Directed: extreme fields, all commands, full table, late load, zero burst.
        pending_items.push_back(make_cmd(CMD_SLICE, 16'd0, 16'd0, 16'd0));
        pending_items.push_back(make_cmd(CMD_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_items.push_back(make_cmd(CMD_LOAD, 16'h0000, 16'hFFFF, 16'h0000));
        pending_items.push_back(make_cmd(CMD_LOAD, 16'h0005, 16'h0000, 16'h0001));
        pending_items.push_back(make_cmd(CMD_LOAD, 16'h0005, 16'h0000, 16'h0009));
        pending_items.push_back(make_cmd(CMD_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        for (int i = 0; i < 5; i++)
            pending_items.push_back(make_cmd(CMD_SLICE, 16'd0, 16'd0, 16'd0));
        pending_items.push_back(make_cmd(CMD_LOAD, 16'd1, 16'd1, 16'd1));
        for (int i = 0; i < 6; i++)
            pending_items.push_back(make_cmd(CMD_SLICE, 16'd0, 16'd0, 16'd0));
        pending_items.push_back(make_cmd(CMD_CLEAR, 16'd0, 16'd0, 16'd0));
        for (int i = 0; i < 17; i++)
            pending_items.push_back(make_cmd(CMD_LOAD, 16'(i), 16'(100 - i), 16'd2));
        pending_items.push_back(make_cmd(CMD_SLICE, 16'd0, 16'd0, 16'd0));
        // Random job sets, quantum changed before every twelfth set.
        count = 0;
        for (int k = 0; count < 1900; k++) begin
            if (k % 12 == 0)
                pending_items.push_back(make_cfg(k < 72 ? quanta[k / 12] : 16'($urandom)));
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
            add_job_set(sz, $urandom_range(0, 3) != 0);
            count = pending_items.size();
        end
    end

    // Driver: commands and register writes change at the falling edge.
    initial
    begin
        start = 1'b0; cfg_we = 1'b0; cfg_data = '0; command = CMD_NOP;
        task_id = '0; arrival_time = '0; burst_length = '0;
        stim_done = 1'b0; send_idle_pct = 30;
        holding = 1'b0;
        drain_wait = 0;
        cfg_writes = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Sampled at the rising edge: whether the current item was accepted.
    always @(posedge clk)
    begin
        accepted <= start && !busy && rst_n;
    end

    // Main sequencing of the driver at falling edges.
    always @(negedge clk)
    begin
        if (rst_n && !stim_done) begin
            if (holding && accepted) begin
                holding = 1'b0;
            end
            if (!holding) begin
                cfg_we <= 1'b0;
                if (pending_items.size() == 0) begin
                    start <= 1'b0;
                    stim_done <= 1'b1;
                end
                else if (pending_items[0].drain &&
                         (expected_slices.size() != 0 || busy || drain_wait < 40)) begin
                    start <= 1'b0;
                    drain_wait <= (expected_slices.size() != 0 || busy) ? 0 : drain_wait + 1;
                end
                else if (pending_items[0].is_cfg) begin
                    cur = pending_items.pop_front();
                    cfg_we <= 1'b1;
                    cfg_data <= cur.cfg_value;
                    quantum = cur.cfg_value;
                    start <= 1'b0;
                    drain_wait <= 0;
                    idle_phase_step();
                end
                else if ($urandom_range(0, 99) < send_idle_pct) begin
                    start <= 1'b0;
                end
                else begin
                    cur = pending_items.pop_front();
                    expected_slices.push_back(predict_slice(cur));
                    command <= cur.cmd;
                    task_id <= cur.id;
                    arrival_time <= cur.arr;
                    burst_length <= cur.burst;
                    start <= 1'b1;
                    holding = 1'b1;
                end
            end
        end
    end

    // Idling phases follow the register writes through the run.
    function automatic void idle_phase_step();
        cfg_writes++;
        if (cfg_writes == 3)
            send_idle_pct = 67;
        else if (cfg_writes == 6)
            send_idle_pct = 0;
    endfunction

    // Monitor: compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        slice_t exp_s;
        if (rst_n && done) begin
            if (expected_slices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: task %0d start %0d", slice_task_id,
                             slice_start);
            end
            else begin
                exp_s = expected_slices.pop_front();
                if (slice_task_id !== exp_s.task_id || slice_start !== exp_s.start_time ||
                    slice_length !== exp_s.length || task_finished !== exp_s.finished ||
                    all_done !== exp_s.all_done || table_full !== exp_s.full) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: exp id %0d st %0d len %0d fin %0b ad %0b ",
                                  "tf %0b, got id %0d st %0d len %0d fin %0b ad %0b tf %0b"},
                                 exp_s.task_id, exp_s.start_time, exp_s.length,
                                 exp_s.finished, exp_s.all_done, exp_s.full,
                                 slice_task_id, slice_start, slice_length,
                                 task_finished, all_done, table_full);
                end
            end
        end
    end

    // Watchdog on accepted items and results.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // End of run.
    initial
    begin
        mismatches = 0;
        stall_cycles = 0;
        wait (stim_done);
        while (expected_slices.size() != 0 && stall_cycles < STALL_LIMIT)
            @(posedge clk);
        if (expected_slices.size() != 0) begin
            $display("Verification failed");
            $finish;
        end
        repeat (60) @(posedge clk);
        if (mismatches == 0 && expected_slices.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Timeout while stimulus is still being sent.
    always @(posedge clk)
    begin
        if (!stim_done && stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // The predictor counters, time and quantum start from their reset values.
    initial
    begin
        quantum = 16'd4;
        rq_head = 0; rq_count = 0; n_loaded = 0; n_admitted = 0;
        sched_time = '0;
    end

endmodule
